// File: rtl/bcd_digit_field_decoder_defines.svh
// Assertion macros for the packed-BCD digit field decoder.
// Included by the RTL file that carries concurrent checks (bdfd_out_stage); no other dependencies.
`ifndef BCD_DIGIT_FIELD_DECODER_DEFINES_SVH
`define BCD_DIGIT_FIELD_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define BDFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define BDFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BDFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define BDFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/bdfd_pkg.sv
// Package for the packed-BCD digit field decoder: mode codes, character
// constants, per-nibble decode function and the result pair type. No dependencies.
package bdfd_pkg;

    localparam logic [2:0] MODE_PLAIN    = 3'd0;
    localparam logic [2:0] MODE_SWAPPED  = 3'd1;
    localparam logic [2:0] MODE_EXTENDED = 3'd2;
    localparam logic [2:0] MODE_FFILL    = 3'd3;
    localparam logic [2:0] MODE_LETTERS  = 3'd4;
    localparam logic [2:0] MODE_SWLETTER = 3'd5;

    localparam logic       CFG_MODE    = 1'b0;
    localparam logic       CFG_PADDING = 1'b1;

    localparam logic [2:0] MODE_RESET    = MODE_SWAPPED;
    localparam logic [7:0] PADDING_RESET = 8'd70;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;

    localparam logic [3:0] NIB_A = 4'ha;
    localparam logic [3:0] NIB_B = 4'hb;
    localparam logic [3:0] NIB_C = 4'hc;
    localparam logic [3:0] NIB_F = 4'hf;

    typedef struct packed {
        logic       keep;
        logic [7:0] ch;
        logic       bad;
    } nib_res_t;

    // Up to two results from one source byte; cnt is 0, 1 or 2.
    typedef struct packed {
        logic [7:0] ch0;
        logic       has0;
        logic [7:0] ch1;
        logic [1:0] cnt;
        logic       last;
        logic       ok;
    } pair_t;

    function automatic nib_res_t decode_nibble(
        input logic [3:0] nib,
        input logic [2:0] mode,
        input logic [7:0] pad
    );
        nib_res_t   r;
        logic [7:0] c;
        logic       checked;
        logic       legal;
        c       = (nib < 4'd10) ? (CH_ZERO + {4'd0, nib}) : (CH_A + {4'd0, nib} - 8'd10);
        checked = 1'b1;
        r.keep  = 1'b1;
        if (mode == MODE_EXTENDED) begin
            if (nib == NIB_A) begin
                c = CH_ZERO;
                checked = 1'b0;
            end else if (nib == NIB_B) begin
                c = CH_HASH;
                checked = 1'b0;
            end else if (nib == NIB_C) begin
                c = CH_STAR;
                checked = 1'b0;
            end
        end
        if (mode == MODE_FFILL && nib == NIB_F) begin
            r.keep = 1'b0;
        end
        if (c == pad) begin
            r.keep = 1'b0;
        end
        legal = (c >= CH_ZERO && c <= CH_NINE)
             || ((mode == MODE_LETTERS || mode == MODE_SWLETTER) && c >= CH_A && c <= CH_E);
        r.bad = r.keep && checked && !legal;
        r.ch  = c;
        return r;
    endfunction

endpackage

// File: rtl/bcd_digit_field_decoder.sv
// Top level of the packed-BCD digit field decoder: configuration registers,
// input register, decode stage and result stage. Uses bdfd_pkg, bdfd_decode, bdfd_out_stage.
//
//   channel   dir   signals                      carries
//   s_axis    in    s_tvalid/s_tready/tdata/tlast  src_byte, last_byte
//   m_axis    out   m_tvalid/m_tready/tdata/tlast/tuser  out_char, end_of_field,
//                                                has_char, field_ok
//   cfg       in    cfg_we/cfg_addr/cfg_data     bcd_mode (0), padding_char (1)
//
// A byte waits in the input register, then in the result stage until every word it
// yields has been taken, one word per transfer; bytes that yield no word are dropped there.
// Sustained rate: one byte per cycle for single-word bytes while m_tready stays high; a
// byte that yields two words holds the result stage until both are taken (single output word port).
// Reset sets mode 1, padding 'F' and re-arms the field-valid flag.
// Input is taken while the result stage still holds a waiting word, if the input register is empty.
module bcd_digit_field_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] src_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,   // end_of_field
    output logic [1:0]  m_tuser,   // [0] has_char, [1] field_ok
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data
);

    logic [2:0]      mode_reg;
    logic [7:0]      padding_reg;
    logic            in_valid_reg;
    logic            in_valid_next;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic            can_load;
    logic            advance;
    logic            in_take;
    bdfd_pkg::pair_t pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= bdfd_pkg::MODE_RESET;
            padding_reg <= bdfd_pkg::PADDING_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bdfd_pkg::CFG_MODE:    mode_reg    <= cfg_data[2:0];
                bdfd_pkg::CFG_PADDING: padding_reg <= cfg_data;
                default:               mode_reg    <= mode_reg;
            endcase
        end
    end

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (in_take) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // hold the byte until the result stage takes it
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bdfd_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .src_byte     (in_byte_reg),
        .last_byte    (in_last_reg),
        .bcd_mode     (mode_reg),
        .padding_char (padding_reg),
        .pair         (pair)
    );

    bdfd_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .pair_in  (pair),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/bdfd_decode.sv
// Decode stage: splits a registered source byte into two nibbles, maps them per
// mode and holds the sticky field-valid flag. Uses bdfd_pkg.
module bdfd_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         src_byte,
    input  logic               last_byte,
    input  logic [2:0]         bcd_mode,
    input  logic [7:0]         padding_char,
    output bdfd_pkg::pair_t    pair
);

    logic               valid_so_far_reg;
    logic               valid_so_far_next;
    logic [2:0]         mode;
    logic               swap;
    logic [3:0]         nib_first;
    logic [3:0]         nib_second;
    bdfd_pkg::nib_res_t res_first;
    bdfd_pkg::nib_res_t res_second;
    logic               byte_ok;

    // Undefined mode codes fall back to plain.
    assign mode = (bcd_mode > bdfd_pkg::MODE_SWLETTER) ? bdfd_pkg::MODE_PLAIN : bcd_mode;
    assign swap = (mode == bdfd_pkg::MODE_SWAPPED) || (mode == bdfd_pkg::MODE_SWLETTER);

    assign nib_first  = swap ? src_byte[3:0] : src_byte[7:4];
    assign nib_second = swap ? src_byte[7:4] : src_byte[3:0];

    assign res_first  = bdfd_pkg::decode_nibble(nib_first, mode, padding_char);
    assign res_second = bdfd_pkg::decode_nibble(nib_second, mode, padding_char);

    assign byte_ok = valid_so_far_reg && !res_first.bad && !res_second.bad;

    always_comb
    begin
        pair.last = last_byte;
        pair.ok   = byte_ok;
        pair.ch1  = res_second.ch;
        if (res_first.keep && res_second.keep) begin
            pair.ch0  = res_first.ch;
            pair.has0 = 1'b1;
            pair.cnt  = 2'd2;
        end else if (res_first.keep) begin
            pair.ch0  = res_first.ch;
            pair.has0 = 1'b1;
            pair.cnt  = 2'd1;
        end else if (res_second.keep) begin
            pair.ch0  = res_second.ch;
            pair.has0 = 1'b1;
            pair.cnt  = 2'd1;
        end else begin
            // empty byte: a final one still yields a bare end-of-field word
            pair.ch0  = 8'd0;
            pair.has0 = 1'b0;
            pair.cnt  = last_byte ? 2'd1 : 2'd0;
        end
    end

    assign valid_so_far_next = last_byte ? 1'b1 : byte_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_so_far_reg <= 1'b1;
        end else if (advance) begin
            valid_so_far_reg <= valid_so_far_next;
        end
    end

endmodule

// File: rtl/bdfd_out_stage.sv
// Result stage: holds one decoded byte's results and hands them out one word
// at a time on the master stream. Uses bdfd_pkg and the assertion macros.
`include "bcd_digit_field_decoder_defines.svh"

module bdfd_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bdfd_pkg::pair_t    pair_in,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_char
    output logic               m_tlast,   // end_of_field
    output logic [1:0]         m_tuser    // [0] has_char, [1] field_ok
);

    bdfd_pkg::pair_t pair_reg;
    logic            valid_reg;
    logic            valid_next;
    logic            idx_reg;
    logic            idx_next;
    logic            final_word;
    logic            take;

    assign final_word = ({1'b0, idx_reg} == (pair_reg.cnt - 2'd1));
    assign take       = valid_reg && m_tready;
    assign can_load   = !valid_reg || (m_tready && final_word);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take) begin
            if (final_word) begin
                valid_next = 1'b0;
                idx_next   = 1'b0;
            end else begin
                idx_next   = 1'b1;
            end
        end
        // drop bytes that give no word
        if (load) begin
            valid_next = (pair_in.cnt != 2'd0);
            idx_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            pair_reg <= pair_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = idx_reg ? pair_reg.ch1 : pair_reg.ch0;
    assign m_tuser[0] = idx_reg ? 1'b1 : pair_reg.has0;
    assign m_tlast    = pair_reg.last && final_word;
    assign m_tuser[1] = pair_reg.last && final_word && pair_reg.ok;

    `BDFD_ASSERT_NOW(a_cnt_nonzero, clk, rst_n, valid_reg, pair_reg.cnt != 2'd0, "empty result held")
    `BDFD_ASSERT_NOW(a_idx_range, clk, rst_n, valid_reg && idx_reg, pair_reg.cnt == 2'd2, "second word of single-result byte")
    `BDFD_ASSERT_NEXT(a_second_follows, clk, rst_n, take && !final_word && !load, valid_reg && idx_reg, "second word lost")
    `BDFD_ASSERT_NOW(a_no_overwrite, clk, rst_n, load, !valid_reg || (take && final_word), "pending word overwritten")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bcd_digit_field_decoder: BCD bytes in, decoded digits out.
// A field-level predictor covers all mode codes and a range of padding settings. Depends on bdfd_pkg.

module tb;
    import bdfd_pkg::*;

    localparam logic [2:0] MODE_UNDEF   = 3'd7;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         N_PHASES     = 12;
    localparam int         PHASE_ITEMS  = 160;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       eof;
        logic       ok;
    } digit_res_t;

    typedef struct packed {
        logic       is_cfg;
        logic       sel;
        logic [7:0] val;
        logic       last;
        logic       typed;
        digit_res_t res;
    } stim_row_t;

    localparam digit_res_t NONE = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam int N_ROWS = 27;

    // Typed results only where they are obvious: empty final words, single kept
    // digits and illegal-character fields.
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 1'b0, 8'hF5, 1'b1, 1'b1, '{8'h35, 1'b1, 1'b1, 1'b1}},
        '{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 8'h21, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'h43, 1'b1, 1'b0, NONE},
        '{1'b1, CFG_MODE, {5'd0, MODE_PLAIN}, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hFE, 1'b1, 1'b1, '{8'h45, 1'b1, 1'b1, 1'b0}},
        '{1'b0, 1'b0, 8'h98, 1'b1, 1'b0, NONE},
        '{1'b1, CFG_MODE, {5'd0, MODE_EXTENDED}, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hAB, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hCF, 1'b1, 1'b0, NONE},
        '{1'b1, CFG_PADDING, CH_HASH, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hBB, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 1'b0, 8'hDB, 1'b1, 1'b1, '{8'h44, 1'b1, 1'b1, 1'b0}},
        '{1'b1, CFG_MODE, {5'd0, MODE_FFILL}, 1'b0, 1'b0, NONE},
        '{1'b1, CFG_PADDING, 8'h00, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 1'b0, 8'h1F, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hF2, 1'b1, 1'b0, NONE},
        '{1'b1, CFG_MODE, {5'd0, MODE_LETTERS}, 1'b0, 1'b0, NONE},
        '{1'b1, CFG_PADDING, CH_F, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hAE, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 8'h0F, 1'b1, 1'b1, '{8'h30, 1'b1, 1'b1, 1'b1}},
        '{1'b1, CFG_MODE, {5'd0, MODE_SWLETTER}, 1'b0, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hCD, 1'b1, 1'b0, NONE},
        '{1'b0, 1'b0, 8'hDF, 1'b1, 1'b1, '{8'h44, 1'b1, 1'b1, 1'b1}}
    };

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] src_byte
    logic       s_tlast;   // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [7:0] out_char
    logic       m_tlast;   // end_of_field
    logic [1:0] m_tuser;   // [0] has_char, [1] field_ok
    logic       cfg_we;
    logic       cfg_addr;
    logic [7:0] cfg_data;

    bcd_digit_field_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Shadow of the decoder state
    logic [2:0]  cur_mode;
    logic [7:0]  cur_pad;
    logic        field_good;

    digit_res_t  pending_digits [$];
    int          fail_count;
    int unsigned cycle_count;
    int          burst_left;
    int          ready_window;
    int          ready_style;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stalls in windows of random style
    always @(posedge clk)
    begin
        if (ready_window == 0)
        begin
            ready_style  = $urandom_range(0, 3);
            ready_window = $urandom_range(8, 80);
        end
        ready_window = ready_window - 1;
        case (ready_style)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ready_window[3];
        endcase
    end

    // Check each accepted output word against the oldest expectation
    always @(posedge clk)
    begin
        digit_res_t got;
        digit_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            if (pending_digits.size() == 0)
            begin
                $error("unexpected word: out_char %h has_char %b end_of_field %b field_ok %b",
                       got.ch, got.has, got.eof, got.ok);
                fail_count++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (got.ch !== want.ch)
                begin
                    $error("out_char: expected %h, got %h", want.ch, got.ch);
                    fail_count++;
                end
                if (got.has !== want.has)
                begin
                    $error("has_char: expected %b, got %b", want.has, got.has);
                    fail_count++;
                end
                if (got.eof !== want.eof)
                begin
                    $error("end_of_field: expected %b, got %b", want.eof, got.eof);
                    fail_count++;
                end
                if (got.ok !== want.ok)
                begin
                    $error("field_ok: expected %b, got %b", want.ok, got.ok);
                    fail_count++;
                end
            end
        end
    end

    // Returns 1 if the nibble yields a kept character; flags an illegal one.
    function automatic logic keep_nibble(input logic [3:0] nib, input logic [2:0] md,
                                         output logic [7:0] c, output logic illegal);
        logic checked;
        logic legal;
        checked = 1'b1;
        illegal = 1'b0;
        c = (nib < 4'd10) ? CH_ZERO + {4'd0, nib} : CH_A + {4'd0, nib} - 8'd10;
        if (md == MODE_EXTENDED)
        begin
            if (nib == NIB_A)
            begin
                c = CH_ZERO;
                checked = 1'b0;
            end
            else if (nib == NIB_B)
            begin
                c = CH_HASH;
                checked = 1'b0;
            end
            else if (nib == NIB_C)
            begin
                c = CH_STAR;
                checked = 1'b0;
            end
        end
        else if (md == MODE_FFILL && nib == NIB_F)
            return 1'b0;
        if (c == cur_pad)
            return 1'b0;
        legal = (c >= CH_ZERO && c <= CH_NINE)
             || ((md == MODE_LETTERS || md == MODE_SWLETTER) && c >= CH_A && c <= CH_E);
        illegal = checked && !legal;
        return 1'b1;
    endfunction

    // Decode one byte into 0, 1 or 2 words and advance the field-valid flag.
    function automatic int predict_digits(input logic [7:0] b, input logic l,
                                          output digit_res_t r0, output digit_res_t r1);
        logic [2:0] md;
        logic       swap;
        logic [3:0] nibs [2];
        logic [7:0] c;
        logic       bad;
        int         n;
        n  = 0;
        r0 = NONE;
        r1 = NONE;
        md = (cur_mode > MODE_SWLETTER) ? MODE_PLAIN : cur_mode;
        swap = (md == MODE_SWAPPED || md == MODE_SWLETTER);
        nibs[0] = swap ? b[3:0] : b[7:4];
        nibs[1] = swap ? b[7:4] : b[3:0];
        for (int k = 0; k < 2; k++)
        begin
            if (keep_nibble(nibs[k], md, c, bad))
            begin
                if (n == 0)
                    r0 = '{c, 1'b1, 1'b0, 1'b0};
                else
                    r1 = '{c, 1'b1, 1'b0, 1'b0};
                n++;
            end
            if (bad)
                field_good = 1'b0;
        end
        if (l)
        begin
            // empty final byte still closes the field with one word
            if (n == 0)
                n = 1;
            if (n == 1)
            begin
                r0.eof = 1'b1;
                r0.ok  = field_good;
            end
            else
            begin
                r1.eof = 1'b1;
                r1.ok  = field_good;
            end
            field_good = 1'b1;
        end
        return n;
    endfunction

    // Present one byte and return at the edge where it is taken.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic push_predicted(input logic [7:0] b, input logic l);
        digit_res_t r0;
        digit_res_t r1;
        int         n;
        n = predict_digits(b, l, r0, r1);
        if (n > 0)
            pending_digits.push_back(r0);
        if (n > 1)
            pending_digits.push_back(r1);
    endtask

    // Hold the input until every expected word is out and the pipe has drained.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_digits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic sel, input logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_MODE)
            cur_mode = val[2:0];
        else
            cur_pad = val;
        @(posedge clk);
    endtask

    function automatic logic [3:0] rand_nibble();
        return ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 15));
    endfunction

    initial
    begin
        logic [7:0] pad;
        logic [7:0] b;
        logic [3:0] n;
        int         sent;
        int         len;
        digit_res_t r0;
        digit_res_t r1;

        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= 8'h00;
        s_tlast      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= CFG_MODE;
        cfg_data     <= 8'h00;
        fail_count   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        ready_window = 0;
        ready_style  = 0;
        cur_mode     = MODE_RESET;
        cur_pad      = PADDING_RESET;
        field_good   = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].is_cfg)
            begin
                wait_idle();
                cfg_write(DIRECTED_ROWS[i].sel, DIRECTED_ROWS[i].val);
            end
            else
            begin
                send_byte(DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].last);
                if (DIRECTED_ROWS[i].typed)
                begin
                    // advance the field flag, take the typed word as the expectation
                    void'(predict_digits(DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].last, r0, r1));
                    pending_digits.push_back(DIRECTED_ROWS[i].res);
                end
                else
                    push_predicted(DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].last);
            end
        end

        // Undefined mode, then extreme padding in plain mode
        wait_idle();
        cfg_write(CFG_MODE, {5'd0, MODE_UNDEF});
        send_byte(8'h5A, 1'b1);
        push_predicted(8'h5A, 1'b1);
        wait_idle();
        cfg_write(CFG_MODE, {5'd0, MODE_PLAIN});
        cfg_write(CFG_PADDING, 8'hFF);
        send_byte(8'hFF, 1'b1);
        push_predicted(8'hFF, 1'b1);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p == 0)
                pad = 8'h00;
            else if (p == 1)
                pad = 8'hFF;
            else
            begin
                n = 4'($urandom_range(0, 15));
                case ($urandom_range(0, 3))
                    0: pad = CH_F;
                    1: pad = (n < 4'd10) ? CH_ZERO + {4'd0, n} : CH_A + {4'd0, n} - 8'd10;
                    2: pad = ($urandom_range(0, 1) == 0) ? CH_HASH : CH_STAR;
                    default: pad = 8'($urandom_range(0, 255));
                endcase
            end
            wait_idle();
            cfg_write(CFG_MODE, (p < 8) ? 8'(p) : 8'($urandom_range(0, 5)));
            cfg_write(CFG_PADDING, pad);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        b = 8'($urandom_range(0, 255));
                    else
                        b = {rand_nibble(), rand_nibble()};
                    send_byte(b, k == len - 1);
                    push_predicted(b, k == len - 1);
                end
                sent += len;
            end
        end

        wait_idle();
        if (pending_digits.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_digits.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bdfd_pkg.sv
rtl/bdfd_decode.sv
rtl/bdfd_out_stage.sv
rtl/bcd_digit_field_decoder.sv
tb/tb.sv
